// File: rtl/spq_pkg.sv
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 16;
	localparam int STORE_W  = PRIO_W - 1;
	localparam int HELD_W   = 5;

	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	typedef enum logic [2:0] {
		ST_ENQUEUED = 3'd0,
		ST_DEQUEUED = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NEG_PRIO = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	// Search wave that travels down the cell chain during a dequeue.
	typedef struct packed {
		logic                      live;
		logic                      found;
		logic signed [PRIO_W-1:0]  best;
		logic        [VALUE_W-1:0] value;
	} wave_t;

	typedef struct packed {
		logic occupied;
		logic load;
	} cell_ctl_t;

endpackage

// File: rtl/spq_cell.sv
module spq_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spq_pkg::cell_ctl_t                ctl,
	input  logic        [31:0]                load_value,
	input  logic        [14:0]                load_prio,
	input  logic signed [15:0]                highest,
	input  logic        [31:0]                next_value,
	input  logic        [14:0]                next_prio,
	output logic        [31:0]                own_value,
	output logic        [14:0]                own_prio,
	input  spq_pkg::wave_t                    wave_in,
	output spq_pkg::wave_t                    wave_out
);
	import spq_pkg::*;

	logic [VALUE_W-1:0]       value_q;
	logic [STORE_W-1:0]       prio_q;
	logic signed [PRIO_W-1:0] prio_ext;
	logic                     match;
	logic                     shift;
	wave_t                    wave_d;
	wave_t                    wave_q;

	assign prio_ext = $signed({1'b0, prio_q});
	assign match    = wave_in.live & ctl.occupied & ~wave_in.found & (prio_ext == highest);
	assign shift    = wave_in.live & (wave_in.found | match);

	always_comb begin
		wave_d       = wave_in;
		wave_d.found = wave_in.found | match;
		// fold every remaining entry into the running maximum; skip the one taken
		if (ctl.occupied && !match && (prio_ext > wave_in.best)) begin
			wave_d.best = prio_ext;
		end
		if (match) begin
			wave_d.value = value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= load_value;
			prio_q  <= load_prio;
		end else if (shift) begin
			// close the gap: take the younger neighbor's entry
			value_q <= next_value;
			prio_q  <= next_prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q <= wave_d;
		end
	end

	assign wave_out  = wave_q;
	assign own_value = value_q;
	assign own_prio  = prio_q;

endmodule

// File: rtl/stable_priority_queue_top.sv
// Channel   Ports                                       Handshake
// request   action, value_in, priority_req              start & ~busy
// result    status, value_out, entries_held             done, one cycle
//
// Enqueue, and dequeue of an empty queue: result in the cycle after the request.
// Dequeue of a held entry: a search wave runs down the chain of CAPACITY cells,
// one cell per cycle, and the result is registered once the wave leaves the last cell;
// busy is high until the result edge, and the next request may come with done.
// Reset clears the entry count and the highest priority; stores are not cleared.
// Results cannot be held off by the receiver.
module stable_priority_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic signed [31:0] value_in,
	input  logic signed [15:0] priority_req,
	output logic               done,
	output logic        [2:0]  status,
	output logic signed [31:0] value_out,
	output logic        [4:0]  entries_held
);
	import spq_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [PRIO_W-1:0] highest_q;
	status_t                  status_q;
	logic [VALUE_W-1:0]       value_q;

	logic                     accept;
	logic                     enq_ok;
	logic [CNT_W+HELD_W-1:0]  count_ext;

	wave_t                    waves [CAPACITY+1];
	logic [VALUE_W-1:0]       cell_value [CAPACITY];
	logic [STORE_W-1:0]       cell_prio  [CAPACITY];

	assign accept = start & ~busy_q;
	assign enq_ok = (action == ACT_ENQUEUE) & ~priority_req[PRIO_W-1]
		& (count_q != CNT_W'(CAPACITY));

	always_comb begin
		waves[0]       = '0;
		waves[0].live  = accept & (action == ACT_DEQUEUE) & (count_q != '0);
		waves[0].found = 1'b0;
		waves[0].best  = '1;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t           ctl;
		logic [VALUE_W-1:0]  nb_value;
		logic [STORE_W-1:0]  nb_prio;

		assign ctl.occupied = (CNT_W'(i) < count_q);
		assign ctl.load     = accept & enq_ok & (count_q == CNT_W'(i));

		if (i == CAPACITY - 1) begin : g_last
			// entry past the end is outside the count after the shift
			assign nb_value = cell_value[i];
			assign nb_prio  = cell_prio[i];
		end else begin : g_mid
			assign nb_value = cell_value[i+1];
			assign nb_prio  = cell_prio[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.load_value (value_in),
			.load_prio  (priority_req[STORE_W-1:0]),
			.highest    (highest_q),
			.next_value (nb_value),
			.next_prio  (nb_prio),
			.own_value  (cell_value[i]),
			.own_prio   (cell_prio[i]),
			.wave_in    (waves[i]),
			.wave_out   (waves[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			count_q   <= '0;
			highest_q <= '1;
		end else begin
			done_q <= 1'b0;
			if (waves[CAPACITY].live) begin
				busy_q    <= 1'b0;
				done_q    <= 1'b1;
				count_q   <= count_q - 1'b1;
				highest_q <= waves[CAPACITY].best;
			end else if (accept) begin
				if (action == ACT_DEQUEUE) begin
					if (count_q == '0) begin
						done_q <= 1'b1;
					end else begin
						busy_q <= 1'b1;
					end
				end else begin
					done_q <= 1'b1;
					if (enq_ok) begin
						count_q <= count_q + 1'b1;
						if (priority_req > highest_q) begin
							highest_q <= priority_req;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (waves[CAPACITY].live) begin
			status_q <= ST_DEQUEUED;
			value_q  <= waves[CAPACITY].value;
		end else if (accept) begin
			if (action == ACT_DEQUEUE) begin
				status_q <= ST_EMPTY;
				value_q  <= '1;
			end else begin
				value_q <= '0;
				priority if (priority_req[PRIO_W-1]) begin
					status_q <= ST_NEG_PRIO;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					status_q <= ST_FULL;
				end else begin
					status_q <= ST_ENQUEUED;
				end
			end
		end
	end

	assign count_ext    = {{HELD_W{1'b0}}, count_q};
	assign busy         = busy_q;
	assign done         = done_q;
	assign status       = status_q;
	assign value_out    = $signed(value_q);
	assign entries_held = count_ext[HELD_W-1:0];

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import spq_pkg::*;

	typedef struct {
		status_t     status;
		logic [31:0] value;
		logic [4:0]  held;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               action = ACT_ENQUEUE;
	logic signed [31:0] value_in = '0;
	logic signed [15:0] priority_req = '0;
	logic               done;
	logic        [2:0]  status;
	logic signed [31:0] value_out;
	logic        [4:0]  entries_held;

	// queue contents as the block should hold them, oldest first
	logic        [VALUE_W-1:0] held_value[CAPACITY];
	logic        [STORE_W-1:0] held_prio[CAPACITY];
	int                        held_count = 0;
	logic signed [PRIO_W-1:0]  top_prio = -1;

	reply_t reply_backlog[$];
	int     mismatches = 0;
	bit     bursting = 1'b0;

	stable_priority_queue_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.value_in(value_in),
		.priority_req(priority_req),
		.done(done),
		.status(status),
		.value_out(value_out),
		.entries_held(entries_held)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic reply_t predict_reply(logic act, logic [31:0] val,
			logic signed [15:0] prio);
		reply_t                   r;
		int                       pick;
		logic signed [PRIO_W-1:0] best;
		r.value = '0;
		if (act == ACT_ENQUEUE) begin
			if (prio < 0) begin
				r.status = ST_NEG_PRIO;
			end else if (held_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				held_value[held_count] = val;
				held_prio[held_count] = prio[STORE_W-1:0];
				held_count++;
				if (prio > top_prio)
					top_prio = prio;
				r.status = ST_ENQUEUED;
			end
		end else if (held_count == 0) begin
			r.status = ST_EMPTY;
			r.value = '1;
		end else begin
			// oldest entry at the top priority leaves first
			pick = 0;
			for (int i = held_count - 1; i >= 0; i--)
				if ($signed({1'b0, held_prio[i]}) == top_prio)
					pick = i;
			r.value = held_value[pick];
			for (int i = pick; i + 1 < held_count; i++) begin
				held_value[i] = held_value[i + 1];
				held_prio[i] = held_prio[i + 1];
			end
			held_count--;
			best = -1;
			for (int i = 0; i < held_count; i++)
				if ($signed({1'b0, held_prio[i]}) > best)
					best = $signed({1'b0, held_prio[i]});
			top_prio = best;
			r.status = ST_DEQUEUED;
		end
		r.held = held_count[4:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (bursting || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_priority();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return {1'b1, 15'($urandom)};
		if (r < 70)
			return 16'($urandom_range(0, 7));
		return {1'b0, 15'($urandom)};
	endfunction

	// hold the request until taken, then record its reply and idle for a random gap, which may be none
	task automatic send_request(input logic act, input logic [31:0] val,
			input logic [15:0] prio);
		int gap;
		start <= 1'b1;
		action <= act;
		value_in <= val;
		priority_req <= prio;
		do @(posedge clk); while (busy);
		reply_backlog.push_back(predict_reply(act, val, prio));
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_empty_dequeue();
		send_request(ACT_DEQUEUE, $urandom, 16'($urandom));
	endtask

	task automatic test_negative_priority();
		send_request(ACT_ENQUEUE, 32'h7fff_ffff, 16'h8000);
		send_request(ACT_ENQUEUE, $urandom, 16'hffff);
	endtask

	task automatic test_fill_to_full();
		logic [31:0] val;
		logic [15:0] prio;
		for (int i = 0; i < CAPACITY; i++) begin
			case (i)
				0: begin val = 32'h8000_0000; prio = 16'd0; end
				1: begin val = 32'h7fff_ffff; prio = 16'h7fff; end
				2: begin val = 32'hffff_ffff; prio = 16'h7fff; end
				default: begin val = $urandom; prio = 16'(i % 3); end
			endcase
			send_request(ACT_ENQUEUE, val, prio);
		end
		send_request(ACT_ENQUEUE, $urandom, 16'd100);
		// negative wins over full
		send_request(ACT_ENQUEUE, $urandom, 16'h8000);
		repeat (3) send_request(ACT_DEQUEUE, $urandom, 16'($urandom));
	endtask

	task automatic test_random_traffic(input int count);
		int mode;
		int enq_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 64 == 0) begin
				mode = $urandom_range(0, 2);
				enq_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
				bursting = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 99) < enq_pct)
				send_request(ACT_ENQUEUE, $urandom, pick_priority());
			else
				send_request(ACT_DEQUEUE, $urandom, 16'($urandom));
		end
		bursting = 1'b0;
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			if (reply_backlog.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d value %h held %0d",
						status, value_out, entries_held);
			end else begin
				want = reply_backlog.pop_front();
				if (status !== want.status || value_out !== want.value ||
						entries_held !== want.held) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want %0d %h %0d, got %0d %h %0d",
							want.status, want.value, want.held,
							status, value_out, entries_held);
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_dequeue();
		test_negative_priority();
		test_fill_to_full();
		test_random_traffic(800);
		start <= 1'b0;
		while (reply_backlog.size() != 0)
			@(posedge clk);
		repeat (CAPACITY + 4) @(posedge clk);
		if (reply_backlog.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
